>>> sv/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
// Field widths, calibration register indexes and the coefficient bundle.
// No dependencies.
package bpc_pkg;

  // Item and register field widths
  localparam int RAW_W   = 24;
  localparam int COEFF_W = 16;
  localparam int RES_W   = 32;
  localparam int CFG_IDX_W = 3;

  // Compensation constants
  localparam int TEMP_REF   = 2000;   // 20.00 degrees
  localparam int COLD_SHIFT = 3500;   // 2000 + 1500, puts -15.00 degrees at zero

  // Number of register stages in the arithmetic pipeline
  localparam int NSTG = 9;

  // Calibration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS     = 3'd0,
    REG_OFF      = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5
  } cfg_reg_t;

  // Calibration coefficients as seen by the datapath
  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] off;
    logic [COEFF_W-1:0] tcs;
    logic [COEFF_W-1:0] tco;
    logic [COEFF_W-1:0] tref;
    logic [COEFF_W-1:0] tempsens;
  } coeff_t;

endpackage

>>> sv/bpc_in_if.sv
// Input channel: one raw pressure and one raw temperature conversion per item.
// Depends on bpc_pkg.
interface bpc_in_if;
  import bpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

>>> sv/bpc_out_if.sv
// Result channel: compensated temperature and pressure per item.
// Depends on bpc_pkg.
interface bpc_out_if;
  import bpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] temp_centideg;
  logic signed [RES_W-1:0] pressure_pascal;

  modport source (output valid, temp_centideg, pressure_pascal, input ready);
  modport sink   (input valid, temp_centideg, pressure_pascal, output ready);
endinterface

>>> sv/bpc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on bpc_pkg.
interface bpc_cfg_if;
  import bpc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEFF_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/bpc_pipe.sv
// Nine-stage compensation datapath with per-stage valid bits and stall logic.
// Depends on bpc_pkg, bpc_in_if and bpc_out_if.
module bpc_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  bpc_pkg::coeff_t coeff,
  bpc_in_if.sink          in_ch,
  bpc_out_if.source       out_ch
);
  import bpc_pkg::*;

  // Stage control
  logic [NSTG:1]   vld_r;
  logic [NSTG+1:1] en;

  always_comb begin
    en[NSTG+1] = out_ch.ready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_ch.valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1: dT = D2 - tref * 256
  logic [RAW_W-1:0] s1_d1_r;
  logic signed [24:0] s1_dt_r, s1_dt_nxt;

  assign s1_dt_nxt = $signed({1'b0, in_ch.raw_temperature})
                   - $signed({1'b0, coeff.tref, 8'h00});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d1_r <= in_ch.raw_pressure;
      s1_dt_r <= s1_dt_nxt;
    end
  end

  // Stage 2: coefficient products and dT squared
  logic [RAW_W-1:0]   s2_d1_r;
  logic signed [41:0] s2_mt_r, s2_mo_r, s2_ms_r;
  logic signed [49:0] s2_mdd_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_d1_r  <= s1_d1_r;
      s2_mt_r  <= s1_dt_r * $signed({1'b0, coeff.tempsens});
      s2_mo_r  <= s1_dt_r * $signed({1'b0, coeff.tco});
      s2_ms_r  <= s1_dt_r * $signed({1'b0, coeff.tcs});
      s2_mdd_r <= s1_dt_r * s1_dt_r;
    end
  end

  // Stage 3: first-order TEMP, OFF, SENS; range flags and deltas
  logic signed [18:0] s3_q;
  logic signed [19:0] s3_temp1_nxt, s3_dv_nxt;
  logic signed [39:0] s3_off1_nxt, s3_sens1_nxt;

  logic [RAW_W-1:0]   s3_d1_r;
  logic signed [19:0] s3_temp1_r, s3_dv_r;
  logic signed [18:0] s3_dl_r;
  logic               s3_low_r, s3_cold_r;
  logic signed [39:0] s3_off1_r, s3_sens1_r;
  logic [17:0]        s3_t2_r;

  // floor shifts are part-selects of the two's complement products
  assign s3_q         = s2_mt_r[41:23];
  assign s3_temp1_nxt = $signed({s3_q[18], s3_q}) + 20'(TEMP_REF);
  assign s3_dv_nxt    = $signed({s3_q[18], s3_q}) + 20'(COLD_SHIFT);
  assign s3_off1_nxt  = $signed({8'h00, coeff.off, 16'h0000})
                      + $signed({{5{s2_mo_r[41]}}, s2_mo_r[41:7]});
  assign s3_sens1_nxt = $signed({9'h000, coeff.sens, 15'h0000})
                      + $signed({{6{s2_ms_r[41]}}, s2_ms_r[41:8]});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_d1_r    <= s2_d1_r;
      s3_temp1_r <= s3_temp1_nxt;
      s3_dl_r    <= s3_q;              // TEMP - 2000
      s3_dv_r    <= s3_dv_nxt;         // TEMP + 1500
      s3_low_r   <= s3_q[18];          // below 20.00 degrees
      s3_cold_r  <= s3_dv_nxt[19];     // below -15.00 degrees
      s3_off1_r  <= s3_off1_nxt;
      s3_sens1_r <= s3_sens1_nxt;
      s3_t2_r    <= s2_mdd_r[48:31];
    end
  end

  // Stage 4: squares of the temperature deltas
  logic [RAW_W-1:0]   s4_d1_r;
  logic signed [19:0] s4_temp1_r;
  logic               s4_low_r, s4_cold_r;
  logic signed [39:0] s4_off1_r, s4_sens1_r;
  logic [17:0]        s4_t2_r;
  logic signed [37:0] s4_sqdl_full;
  logic signed [39:0] s4_sqdv_full;
  logic [35:0]        s4_sqdl_r, s4_sqdv_r;

  assign s4_sqdl_full = s3_dl_r * s3_dl_r;
  assign s4_sqdv_full = s3_dv_r * s3_dv_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_d1_r    <= s3_d1_r;
      s4_temp1_r <= s3_temp1_r;
      s4_low_r   <= s3_low_r;
      s4_cold_r  <= s3_cold_r;
      s4_off1_r  <= s3_off1_r;
      s4_sens1_r <= s3_sens1_r;
      s4_t2_r    <= s3_t2_r;
      s4_sqdl_r  <= s4_sqdl_full[35:0];
      s4_sqdv_r  <= s4_sqdv_full[35:0];
    end
  end

  // Stage 5: second-order OFF2 and SENS2 (all terms non-negative)
  logic [39:0] s5_five, s5_seven, s5_eleven;
  logic [39:0] s5_off2_nxt, s5_sens2_nxt;

  assign s5_five   = {2'b00, s4_sqdl_r, 2'b00} + {4'h0, s4_sqdl_r};
  assign s5_seven  = {1'b0, s4_sqdv_r, 3'b000} - {4'h0, s4_sqdv_r};
  assign s5_eleven = {1'b0, s4_sqdv_r, 3'b000} + {3'b000, s4_sqdv_r, 1'b0}
                   + {4'h0, s4_sqdv_r};
  assign s5_off2_nxt  = {1'b0, s5_five[39:1]}
                      + (s4_cold_r ? s5_seven : 40'd0);
  assign s5_sens2_nxt = {2'b00, s5_five[39:2]}
                      + (s4_cold_r ? {1'b0, s5_eleven[39:1]} : 40'd0);

  logic [RAW_W-1:0]   s5_d1_r;
  logic signed [19:0] s5_temp1_r;
  logic               s5_low_r;
  logic signed [39:0] s5_off1_r, s5_sens1_r;
  logic [17:0]        s5_t2_r;
  logic [39:0]        s5_off2_r, s5_sens2_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_d1_r    <= s4_d1_r;
      s5_temp1_r <= s4_temp1_r;
      s5_low_r   <= s4_low_r;
      s5_off1_r  <= s4_off1_r;
      s5_sens1_r <= s4_sens1_r;
      s5_t2_r    <= s4_t2_r;
      s5_off2_r  <= s5_off2_nxt;
      s5_sens2_r <= s5_sens2_nxt;
    end
  end

  // Stage 6: apply the correction below 20.00 degrees
  logic [RAW_W-1:0]   s6_d1_r;
  logic signed [20:0] s6_temp_r;
  logic signed [39:0] s6_off_r, s6_sens_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_d1_r <= s5_d1_r;
      if (s5_low_r) begin
        s6_temp_r <= $signed({s5_temp1_r[19], s5_temp1_r})
                   - $signed({3'b000, s5_t2_r});
        s6_off_r  <= s5_off1_r - $signed(s5_off2_r);
        s6_sens_r <= s5_sens1_r - $signed(s5_sens2_r);
      end else begin
        s6_temp_r <= $signed({s5_temp1_r[19], s5_temp1_r});
        s6_off_r  <= s5_off1_r;
        s6_sens_r <= s5_sens1_r;
      end
    end
  end

  // Stage 7: D1 * SENS as two partial products on SENS halves
  logic signed [20:0] s7_temp_r;
  logic signed [39:0] s7_off_r;
  logic [43:0]        s7_pplo_r;
  logic signed [44:0] s7_pphi_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_temp_r <= s6_temp_r;
      s7_off_r  <= s6_off_r;
      s7_pplo_r <= s6_d1_r * s6_sens_r[19:0];
      s7_pphi_r <= $signed({1'b0, s6_d1_r}) * $signed(s6_sens_r[39:20]);
    end
  end

  // Stage 8: combine partial products
  logic signed [20:0] s8_temp_r;
  logic signed [39:0] s8_off_r;
  logic signed [64:0] s8_prod_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_temp_r <= s7_temp_r;
      s8_off_r  <= s7_off_r;
      s8_prod_r <= $signed({s7_pphi_r, 20'h00000})
                 + $signed({21'h0, s7_pplo_r});
    end
  end

  // Stage 9: P = floor((floor(D1*SENS / 2^21) - OFF) / 2^15), output register
  logic signed [44:0] s9_diff;
  logic signed [RES_W-1:0] s9_temp_r, s9_pres_r;

  assign s9_diff = $signed({s8_prod_r[64], s8_prod_r[64:21]})
                 - $signed({{5{s8_off_r[39]}}, s8_off_r});

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_temp_r <= $signed({{(RES_W-21){s8_temp_r[20]}}, s8_temp_r});
      s9_pres_r <= $signed({{(RES_W-30){s9_diff[44]}}, s9_diff[44:15]});
    end
  end

  assign out_ch.valid           = vld_r[NSTG];
  assign out_ch.temp_centideg   = s9_temp_r;
  assign out_ch.pressure_pascal = s9_pres_r;

  // Checks
  logic in_acc, out_acc;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline not empty after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NSTG] |-> in_ch.ready)
    else $error("input stalled with free output stage");

  a_occ_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_acc) |=> $countones(vld_r) == $past($countones(vld_r)) + 1)
    else $error("item lost or invented on entry");

  a_occ_same: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc == out_acc) |=> $countones(vld_r) == $past($countones(vld_r)))
    else $error("pipeline occupancy changed without a handshake");

  a_cold_low: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && s3_cold_r) |-> s3_low_r)
    else $error("cold flag without low-temperature flag");

endmodule

>>> sv/barometric_pressure_compensation.sv
// Barometric pressure compensation: an accepted input passes through 9 pipeline
// register stages to out_ch; the last stage is the output register.
// Throughput one item per clock while out_ch is ready; a stalled output holds its item
// and back-pressure propagates stage by stage in the datapath, squeezing out bubbles.
// Synchronous active-low reset clears all valid bits and sets the six calibration
// coefficients to zero; cfg_ch is always ready, writes to indexes above 5 are ignored.
module barometric_pressure_compensation (
  input  logic      clk,
  input  logic      rst_n,
  bpc_in_if.sink    in_ch,
  bpc_out_if.source out_ch,
  bpc_cfg_if.sink   cfg_ch
);
  import bpc_pkg::*;

  // Calibration registers
  coeff_t coeff_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_SENS:     coeff_r.sens     <= cfg_ch.data;
        REG_OFF:      coeff_r.off      <= cfg_ch.data;
        REG_TCS:      coeff_r.tcs      <= cfg_ch.data;
        REG_TCO:      coeff_r.tco      <= cfg_ch.data;
        REG_TREF:     coeff_r.tref     <= cfg_ch.data;
        REG_TEMPSENS: coeff_r.tempsens <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Compensation datapath
  bpc_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .coeff  (coeff_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

>>> dv/bpc_result_checker.sv
// Result checker for the barometric pressure compensation block: tracks calibration
// writes, predicts one result per accepted reading and compares results in order.
// Depends on bpc_pkg and the bpc_in_if, bpc_out_if and bpc_cfg_if interfaces.
module bpc_result_checker (
  input  logic clk,
  input  logic rst_n,
  bpc_in_if    in_ch,
  bpc_out_if   out_ch,
  bpc_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import bpc_pkg::*;

  localparam longint COLD_LIMIT = -1500;  // -15.00 degrees

  typedef struct packed {
    logic signed [RES_W-1:0] temp_centideg;
    logic signed [RES_W-1:0] pressure_pascal;
  } comp_result_t;

  coeff_t       cal;
  comp_result_t expected_q[$];

  // Second-order compensation of one reading pair; all intermediates 64-bit signed,
  // >>> on signed operands floors toward minus infinity.
  function automatic comp_result_t compensate(input coeff_t k,
                                              input logic [RAW_W-1:0] d1_raw,
                                              input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, dt, temp, off, sens, t2, dl, off2, sens2, dv, p;
    comp_result_t r;
    d1   = longint'(d1_raw);
    d2   = longint'(d2_raw);
    dt   = d2 - longint'(k.tref) * 256;
    temp = TEMP_REF + ((dt * longint'(k.tempsens)) >>> 23);
    off  = longint'(k.off) * 65536 + ((longint'(k.tco) * dt) >>> 7);
    sens = longint'(k.sens) * 32768 + ((longint'(k.tcs) * dt) >>> 8);
    // cold correction below 20.00, extra term below -15.00
    if (temp < TEMP_REF) begin
      t2    = (dt * dt) >>> 31;
      dl    = temp - TEMP_REF;
      off2  = (5 * dl * dl) >>> 1;
      sens2 = (5 * dl * dl) >>> 2;
      if (temp < COLD_LIMIT) begin
        dv    = temp - COLD_LIMIT;
        off2  = off2 + 7 * dv * dv;
        sens2 = sens2 + ((11 * dv * dv) >>> 1);
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    r.temp_centideg   = temp[RES_W-1:0];
    r.pressure_pascal = p[RES_W-1:0];
    return r;
  endfunction

  // Sample all three channels at the rising edge
  always @(posedge clk) begin
    comp_result_t want;
    if (!rst_n) begin
      cal = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      // calibration write; spare indexes are ignored
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_SENS:     cal.sens     = cfg_ch.data;
          REG_OFF:      cal.off      = cfg_ch.data;
          REG_TCS:      cal.tcs      = cfg_ch.data;
          REG_TCO:      cal.tco      = cfg_ch.data;
          REG_TREF:     cal.tref     = cfg_ch.data;
          REG_TEMPSENS: cal.tempsens = cfg_ch.data;
          default: ;
        endcase
      end
      // result against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no reading pending: temp %0d pressure %0d",
                   $time, out_ch.temp_centideg, out_ch.pressure_pascal);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.temp_centideg !== want.temp_centideg) begin
            fail_count++;
            $display("%0t: temp_centideg expected %0d actual %0d",
                     $time, want.temp_centideg, out_ch.temp_centideg);
          end
          if (out_ch.pressure_pascal !== want.pressure_pascal) begin
            fail_count++;
            $display("%0t: pressure_pascal expected %0d actual %0d",
                     $time, want.pressure_pascal, out_ch.pressure_pascal);
          end
        end
      end
      // new reading pair
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(compensate(cal, in_ch.raw_pressure, in_ch.raw_temperature));
    end
    pending = expected_q.size();
  end

endmodule

>>> dv/barometric_pressure_compensation_tb.sv
// Testbench top for barometric_pressure_compensation: clock, reset, calibration
// phases, directed and random readings with random idling on both channels.
// Depends on bpc_pkg, the three channel interfaces, the block and bpc_result_checker.
module barometric_pressure_compensation_tb;
  import bpc_pkg::*;

  // Register indexes beyond the last coefficient
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 220;

  logic clk;
  logic rst_n;
  int   results_outstanding;
  int   compare_failures;
  int   in_idle_pct;
  int   out_idle_pct;

  bpc_in_if  in_ch();
  bpc_out_if out_ch();
  bpc_cfg_if cfg_ch();

  barometric_pressure_compensation dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bpc_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (compare_failures),
    .pending    (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("barometric_pressure_compensation_tb: FAIL");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  // Offer one reading pair; called and returns at a falling edge
  task automatic send_reading(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
    int gap;
    gap = idle_len(in_idle_pct);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.raw_pressure    <= p;
    in_ch.raw_temperature <= t;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_coeff(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEFF_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    repeat (1 + idle_len(30)) @(negedge clk);
  endtask

  // Drain, then write all six coefficients in random order and both spare indexes
  task automatic load_coeffs(input coeff_t k);
    logic [CFG_IDX_W-1:0] order [6];
    logic [CFG_IDX_W-1:0] tmp;
    int i, j;
    in_ch.valid <= 1'b0;
    wait (results_outstanding == 0);
    @(negedge clk);
    order = '{REG_SENS, REG_OFF, REG_TCS, REG_TCO, REG_TREF, REG_TEMPSENS};
    for (i = 5; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < 6; i++) begin
      case (cfg_reg_t'(order[i]))
        REG_SENS:     write_coeff(order[i], k.sens);
        REG_OFF:      write_coeff(order[i], k.off);
        REG_TCS:      write_coeff(order[i], k.tcs);
        REG_TCO:      write_coeff(order[i], k.tco);
        REG_TREF:     write_coeff(order[i], k.tref);
        REG_TEMPSENS: write_coeff(order[i], k.tempsens);
        default: ;
      endcase
    end
    write_coeff(IDX_SPARE_A, COEFF_W'($urandom));
    write_coeff(IDX_SPARE_B, COEFF_W'($urandom));
  endtask

  // Result side back-pressure
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = idle_len(out_idle_pct);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Stimulus and verdict
  initial begin
    coeff_t               k;
    longint               tref_raw, dt_cold, v;
    logic [RAW_W-1:0]     d1, d2;
    int                   ph, n;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.raw_pressure    = '0;
    in_ch.raw_temperature = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    in_idle_pct           = 30;
    out_idle_pct          = 30;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Coefficients still at reset
    send_reading('0, '0);
    send_reading('1, '1);

    // Typical calibration: warm, exactly 20.00, just below, the -15.00 edge, coldest
    k = '{sens: 16'd40127, off: 16'd36924, tcs: 16'd23317, tco: 16'd23282,
          tref: 16'd33464, tempsens: 16'd28312};
    load_coeffs(k);
    tref_raw = longint'(k.tref) * 256;
    dt_cold  = -((longint'(3500) * 8388608) / longint'(k.tempsens));
    send_reading(24'd9085466, 24'd8569150);
    send_reading('0, 24'd8569150);
    send_reading('1, 24'd8569150);
    send_reading(24'd9085466, RAW_W'(tref_raw));
    send_reading(24'd9085466, RAW_W'(tref_raw - 1));
    send_reading('1, RAW_W'(tref_raw + dt_cold));
    send_reading('1, RAW_W'(tref_raw + dt_cold - 1));
    send_reading('1, '0);
    send_reading('0, '0);
    send_reading('1, '1);

    // All coefficients at full scale
    load_coeffs('1);
    send_reading('1, '0);
    send_reading('1, '1);
    send_reading('0, '0);
    send_reading('1, 24'hFFFF00);

    // Random phases, each with its own calibration and idling mix
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        2: k = '1;
        5: k = '0;
        default: begin
          if (ph % 2) begin
            k = {$urandom, $urandom, $urandom};
          end else begin
            k.sens     = COEFF_W'(40127 + $urandom_range(8191) - 4096);
            k.off      = COEFF_W'(36924 + $urandom_range(8191) - 4096);
            k.tcs      = COEFF_W'(23317 + $urandom_range(8191) - 4096);
            k.tco      = COEFF_W'(23282 + $urandom_range(8191) - 4096);
            k.tref     = COEFF_W'(33464 + $urandom_range(8191) - 4096);
            k.tempsens = COEFF_W'(28312 + $urandom_range(8191) - 4096);
          end
        end
      endcase
      case (ph % 3)
        0: begin in_idle_pct = 0;  out_idle_pct = 30; end
        1: begin in_idle_pct = 30; out_idle_pct = 70; end
        default: begin in_idle_pct = 70; out_idle_pct = 0; end
      endcase
      load_coeffs(k);
      tref_raw = longint'(k.tref) * 256;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(7) == 0)
          d1 = $urandom_range(1) ? '1 : '0;
        else
          d1 = RAW_W'($urandom);
        case ($urandom_range(3))
          // around the reference temperature, both sides of 20.00 and -15.00
          2: begin
            v = tref_raw + longint'($urandom_range(4194304)) - 2097152;
            if (v < 0) v = 0;
            if (v > 16777215) v = 16777215;
            d2 = RAW_W'(v);
          end
          // near the ends of the raw range
          3: d2 = $urandom_range(1) ? RAW_W'($urandom_range(255))
                                    : RAW_W'(24'hFFFFFF - $urandom_range(255));
          default: d2 = RAW_W'($urandom);
        endcase
        send_reading(d1, d2);
      end
    end

    // Drain and give the verdict
    in_ch.valid <= 1'b0;
    wait (results_outstanding == 0);
    repeat (NSTG + 4) @(negedge clk);
    if (compare_failures == 0) begin
      $display("barometric_pressure_compensation_tb: PASS");
    end else begin
      $display("barometric_pressure_compensation_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bpc_pkg.sv
sv/bpc_in_if.sv
sv/bpc_out_if.sv
sv/bpc_cfg_if.sv
sv/bpc_pipe.sv
sv/barometric_pressure_compensation.sv
dv/bpc_result_checker.sv
dv/barometric_pressure_compensation_tb.sv
